// ===== hdl/brp_pkg.sv =====
// Shared types, constants and codes for the bounding box point rescaler.
package brp_pkg;

    // Capacity and derived widths
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Two point banks, one per queue slot
    localparam int QUEUE_DEPTH = 2;
    localparam int BANK_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_AW      = BANK_W + IDX_W;
    localparam int RAM_DEPTH   = 2 ** RAM_AW;

    // Field widths
    localparam int COORD_W = 32;
    localparam int FRAME_W = 16;
    localparam int RAM_W   = 2 * COORD_W;

    // Scaling datapath: 32 x 16 product, quotient never exceeds 16 bits
    localparam int MAG_W   = FRAME_W;
    localparam int PROD_W  = COORD_W + MAG_W;
    localparam int QUO_W   = FRAME_W + 1;
    localparam int DIVC_W  = $clog2(QUO_W);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_FRAME_MAX_X = 2'd0;
    localparam logic [1:0] REG_FRAME_MIN_X = 2'd1;
    localparam logic [1:0] REG_FRAME_MAX_Y = 2'd2;
    localparam logic [1:0] REG_FRAME_MIN_Y = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_X   = 2'd1,
        ST_ZERO_Y   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_READ,
        BK_DIFF,
        BK_MULT,
        BK_DIV,
        BK_POST,
        BK_EMIT
    } bk_state_t;

    // One finished set as handed from front to back
    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] hi_y;
        logic [CNT_W-1:0]          count;
        logic                      ovf;
    } desc_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [BANK_W-1:0] wr_bank;
        logic [BANK_W-1:0] rd_bank;
    } q_stat_t;

    typedef struct packed {
        logic signed [FRAME_W-1:0] fmax_x;
        logic signed [FRAME_W-1:0] fmin_x;
        logic signed [FRAME_W-1:0] fmax_y;
        logic signed [FRAME_W-1:0] fmin_y;
    } frame_cfg_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [RAM_W-1:0]  data;
    } ram_wr_t;

endpackage

// ===== hdl/bounding_box_point_rescaler.sv =====
// Top level: configuration registers, front, queue, point RAM and back end.
// Throughput: one point per cycle while a bank is free; each mapped word is paced by
// the 17-step shared serial divider run once per axis; the next set loads meanwhile.
// Reset: aresetn synchronous, active low; clears control and frame registers, not RAM.
module bounding_box_point_rescaler
    import brp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      s_last_point,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FRAME_W-1:0] m_map_x,
    output logic signed [FRAME_W-1:0] m_map_y,
    output logic [1:0]                m_status,
    output logic                      m_last_result
);

    logic [FRAME_W-1:0] frame_max_x_reg, frame_min_x_reg;
    logic [FRAME_W-1:0] frame_max_y_reg, frame_min_y_reg;
    logic [1:0]         reg_idx;
    logic               cfg_wr;
    logic [FRAME_W-1:0] rd_val;

    frame_cfg_t         cfg;
    q_stat_t            q_stat;
    desc_t              desc_push, desc_head;
    ram_wr_t            ram_wr;
    logic               push, pop, in_acc;
    logic               ram_rd_en;
    logic [RAM_AW-1:0]  ram_rd_addr;
    logic [RAM_W-1:0]   ram_rd_data;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Frame registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_max_x_reg <= '0;
            frame_min_x_reg <= '0;
            frame_max_y_reg <= '0;
            frame_min_y_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FRAME_MAX_X: frame_max_x_reg <= pwdata[FRAME_W-1:0];
                REG_FRAME_MIN_X: frame_min_x_reg <= pwdata[FRAME_W-1:0];
                REG_FRAME_MAX_Y: frame_max_y_reg <= pwdata[FRAME_W-1:0];
                REG_FRAME_MIN_Y: frame_min_y_reg <= pwdata[FRAME_W-1:0];
                default: frame_max_x_reg <= frame_max_x_reg;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_FRAME_MAX_X: rd_val = frame_max_x_reg;
            REG_FRAME_MIN_X: rd_val = frame_min_x_reg;
            REG_FRAME_MAX_Y: rd_val = frame_max_y_reg;
            REG_FRAME_MIN_Y: rd_val = frame_min_y_reg;
            default:         rd_val = '0;
        endcase
    end
    assign prdata = PDATA_W'(rd_val);

    assign cfg.fmax_x = frame_max_x_reg;
    assign cfg.fmin_x = frame_min_x_reg;
    assign cfg.fmax_y = frame_max_y_reg;
    assign cfg.fmin_y = frame_min_y_reg;

    // Accept a point word whenever a bank is free
    assign s_ready = !q_stat.full;
    assign in_acc  = s_valid && s_ready;

    brp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (in_acc),
        .point_x    (s_point_x),
        .point_y    (s_point_y),
        .last_point (s_last_point),
        .q_stat     (q_stat),
        .ram_wr     (ram_wr),
        .push       (push),
        .desc_out   (desc_push)
    );

    brp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .desc_in  (desc_push),
        .pop      (pop),
        .desc_out (desc_head),
        .q_stat   (q_stat)
    );

    brp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    brp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .desc          (desc_head),
        .cfg           (cfg),
        .pop           (pop),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_map_x       (m_map_x),
        .m_map_y       (m_map_y),
        .m_status      (m_status),
        .m_last_result (m_last_result)
    );

endmodule

// ===== hdl/brp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, then registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/brp_front.sv =====
// Front end: accepts points, stores them and tracks the per-axis extremes.
module brp_front
    import brp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_acc,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic                      last_point,
    input  q_stat_t                   q_stat,
    output ram_wr_t                   ram_wr,
    output logic                      push,
    output desc_t                     desc_out
);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic signed [COORD_W-1:0] lo_x_reg, lo_x_next;
    logic signed [COORD_W-1:0] hi_x_reg, hi_x_next;
    logic signed [COORD_W-1:0] lo_y_reg, lo_y_next;
    logic signed [COORD_W-1:0] hi_y_reg, hi_y_next;

    logic                      room;
    logic                      first;
    logic signed [COORD_W-1:0] lo_x_upd, hi_x_upd, lo_y_upd, hi_y_upd;
    logic [CNT_W-1:0]          count_upd;
    logic                      ovf_upd;

    assign room  = count_reg < CNT_W'(MAX_POINTS);
    assign first = count_reg == '0;

    // Fold the new point into the extremes; the first point of a set loads them
    always_comb begin
        lo_x_upd  = lo_x_reg;
        hi_x_upd  = hi_x_reg;
        lo_y_upd  = lo_y_reg;
        hi_y_upd  = hi_y_reg;
        count_upd = count_reg;
        ovf_upd   = ovf_reg;
        if (room) begin
            if (first || point_x < lo_x_reg) lo_x_upd = point_x;
            if (first || point_x > hi_x_reg) hi_x_upd = point_x;
            if (first || point_y < lo_y_reg) lo_y_upd = point_y;
            if (first || point_y > hi_y_reg) hi_y_upd = point_y;
            count_upd = count_reg + CNT_W'(1);
        end else begin
            ovf_upd = 1'b1;
        end
    end

    // Advance the set, or close it on the last word
    always_comb begin
        lo_x_next  = lo_x_reg;
        hi_x_next  = hi_x_reg;
        lo_y_next  = lo_y_reg;
        hi_y_next  = hi_y_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_acc) begin
            if (last_point) begin
                lo_x_next  = '0;
                hi_x_next  = '0;
                lo_y_next  = '0;
                hi_y_next  = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                lo_x_next  = lo_x_upd;
                hi_x_next  = hi_x_upd;
                lo_y_next  = lo_y_upd;
                hi_y_next  = hi_y_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_x_reg  <= '0;
            hi_x_reg  <= '0;
            lo_y_reg  <= '0;
            hi_y_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            lo_x_reg  <= lo_x_next;
            hi_x_reg  <= hi_x_next;
            lo_y_reg  <= lo_y_next;
            hi_y_reg  <= hi_y_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Store the point in the bank of the next free queue slot
    assign ram_wr.en   = in_acc && room;
    assign ram_wr.addr = {q_stat.wr_bank, count_reg[IDX_W-1:0]};
    assign ram_wr.data = {point_y, point_x};

    // Hand the finished set to the back end
    assign push           = in_acc && last_point;
    assign desc_out.lo_x  = lo_x_upd;
    assign desc_out.hi_x  = hi_x_upd;
    assign desc_out.lo_y  = lo_y_upd;
    assign desc_out.hi_y  = hi_y_upd;
    assign desc_out.count = count_upd;
    assign desc_out.ovf   = ovf_upd;

endmodule

// ===== hdl/brp_queue.sv =====
// Short queue of finished sets between front and back; slot index is the bank.
module brp_queue
    import brp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  desc_t   desc_in,
    input  logic    pop,
    output desc_t   desc_out,
    output q_stat_t q_stat
);

    desc_t              slot_reg [QUEUE_DEPTH];
    logic [BANK_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [BANK_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) wr_ptr_next = wr_ptr_reg + BANK_W'(1);
        if (pop)  rd_ptr_next = rd_ptr_reg + BANK_W'(1);
        if (push && !pop) fill_next = fill_reg + QCNT_W'(1);
        if (pop && !push) fill_next = fill_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the set descriptors
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= desc_in;
        end
    end

    assign desc_out       = slot_reg[rd_ptr_reg];
    assign q_stat.full    = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty   = fill_reg == '0;
    assign q_stat.wr_bank = wr_ptr_reg;
    assign q_stat.rd_bank = rd_ptr_reg;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("set pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("set popped from an empty queue");
`endif

endmodule

// ===== hdl/brp_back.sv =====
// Back end: maps each stored point into the frame with a shared serial divider.
module brp_back
    import brp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  q_stat_t             q_stat,
    input  desc_t               desc,
    input  frame_cfg_t          cfg,
    output logic                pop,
    output logic                ram_rd_en,
    output logic [RAM_AW-1:0]   ram_rd_addr,
    input  logic [RAM_W-1:0]    ram_rd_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [FRAME_W-1:0]  m_map_x,
    output logic [FRAME_W-1:0]  m_map_y,
    output logic [1:0]          m_status,
    output logic                m_last_result
);

    bk_state_t state_reg, state_next;

    logic [IDX_W-1:0]   idx_reg;
    logic               axis_reg;
    logic [COORD_W-1:0] rng_x_reg, rng_y_reg;
    status_t            err_reg;
    logic [COORD_W-1:0] diff_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;
    logic [FRAME_W-1:0] mx_reg, my_reg;

    logic               m_valid_reg;
    logic [FRAME_W-1:0] m_map_x_reg, m_map_y_reg;
    logic [1:0]         m_status_reg;
    logic               m_last_reg;

    status_t                   err_now;
    logic                      last_pt;
    logic                      out_free;
    logic                      out_load;
    logic signed [COORD_W-1:0] p_sel, lo_sel;
    logic signed [FRAME_W-1:0] fmax_sel, fmin_sel;
    logic signed [FRAME_W:0]   f_span;
    logic [FRAME_W:0]          f_abs;
    logic [COORD_W-1:0]        den;
    logic [PROD_W-1:0]         prod;
    logic [COORD_W:0]          trial;
    logic [COORD_W:0]          trial_sub;
    logic                      ge;
    logic [QUO_W-1:0]          q_signed;
    logic [FRAME_W-1:0]        res;

    // Classify the head set
    always_comb begin
        if (desc.hi_x == desc.lo_x) begin
            err_now = ST_ZERO_X;
        end else if (desc.hi_y == desc.lo_y) begin
            err_now = ST_ZERO_Y;
        end else begin
            err_now = ST_OK;
        end
    end

    assign last_pt  = (CNT_W'(idx_reg) + CNT_W'(1)) == desc.count;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) state_next = BK_START;
            end
            BK_START: begin
                state_next = (err_now != ST_OK) ? BK_EMIT : BK_READ;
            end
            BK_READ:  state_next = BK_DIFF;
            BK_DIFF:  state_next = BK_MULT;
            BK_MULT:  state_next = BK_DIV;
            BK_DIV: begin
                if (div_cnt_reg == '0) state_next = BK_POST;
            end
            BK_POST: begin
                state_next = axis_reg ? BK_EMIT : BK_DIFF;
            end
            BK_EMIT: begin
                if (out_free) begin
                    state_next = (err_reg != ST_OK || last_pt) ? BK_IDLE : BK_READ;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ram_rd_en = 1'b0;
        out_load  = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            BK_READ: ram_rd_en = 1'b1;
            BK_EMIT: begin
                out_load = out_free;
                pop      = out_free && (err_reg != ST_OK || last_pt);
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    assign ram_rd_addr = {q_stat.rd_bank, idx_reg};

    // Axis selection; RAM word holds y above x
    assign p_sel    = axis_reg ? ram_rd_data[RAM_W-1:COORD_W] : ram_rd_data[COORD_W-1:0];
    assign lo_sel   = axis_reg ? desc.lo_y : desc.lo_x;
    assign fmax_sel = axis_reg ? cfg.fmax_y : cfg.fmax_x;
    assign fmin_sel = axis_reg ? cfg.fmin_y : cfg.fmin_x;
    assign den      = axis_reg ? rng_y_reg : rng_x_reg;

    // Frame span as sign and magnitude
    assign f_span = {fmax_sel[FRAME_W-1], fmax_sel} - {fmin_sel[FRAME_W-1], fmin_sel};
    assign f_abs  = f_span[FRAME_W] ? (FRAME_W+1)'(-f_span) : f_span;

    // Offset times span magnitude
    assign prod = PROD_W'(diff_reg) * PROD_W'(mag_reg);

    // One restoring division step per cycle
    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, den};
    assign ge        = trial >= {1'b0, den};

    // Apply sign and frame origin
    assign q_signed = neg_reg ? (QUO_W)'(-quo_reg) : quo_reg;
    assign res      = fmin_sel + q_signed[FRAME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            axis_reg <= 1'b0;
        end else begin
            case (state_reg)
                BK_START: begin
                    rng_x_reg <= desc.hi_x - desc.lo_x;
                    rng_y_reg <= desc.hi_y - desc.lo_y;
                    err_reg   <= err_now;
                    idx_reg   <= '0;
                end
                BK_READ: axis_reg <= 1'b0;
                BK_DIFF: begin
                    diff_reg <= p_sel - lo_sel;
                    neg_reg  <= f_span[FRAME_W];
                    mag_reg  <= f_abs[MAG_W-1:0];
                end
                BK_MULT: begin
                    rem_reg     <= COORD_W'(prod[PROD_W-1:QUO_W]);
                    quo_reg     <= prod[QUO_W-1:0];
                    div_cnt_reg <= DIVC_W'(QUO_W - 1);
                end
                BK_DIV: begin
                    rem_reg     <= ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
                    quo_reg     <= {quo_reg[QUO_W-2:0], ge};
                    div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
                end
                BK_POST: begin
                    if (axis_reg) begin
                        my_reg <= res;
                    end else begin
                        mx_reg   <= res;
                        axis_reg <= 1'b1;
                    end
                end
                BK_EMIT: begin
                    if (out_load && !last_pt) idx_reg <= idx_reg + IDX_W'(1);
                end
                default: begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (err_reg != ST_OK) begin
                m_map_x_reg  <= '0;
                m_map_y_reg  <= '0;
                m_status_reg <= err_reg;
                m_last_reg   <= 1'b1;
            end else begin
                m_map_x_reg  <= mx_reg;
                m_map_y_reg  <= my_reg;
                m_status_reg <= desc.ovf ? ST_OVERFLOW : ST_OK;
                m_last_reg   <= last_pt;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_map_x       = m_map_x_reg;
    assign m_map_y       = m_map_y_reg;
    assign m_status      = m_status_reg;
    assign m_last_result = m_last_reg;

`ifndef NO_ASSERTIONS
    a_div_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DIV |-> den != '0)
        else $error("division started with a zero range");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_ZERO_X || m_status_reg == ST_ZERO_Y)
            |-> m_last_reg)
        else $error("range error word not marked last");
`endif

endmodule

// ===== dv/bounding_box_point_rescaler_test.sv =====
// Self-checking testbench for the bounding box point rescaler: point sets in, results checked.
module bounding_box_point_rescaler_test;
    import brp_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_CAP   = 100;
    localparam int COORD_MAX    = 32'h7fff_ffff;
    localparam int COORD_MIN    = -COORD_MAX - 1;

    typedef enum {SHAPE_WIDE, SHAPE_NARROW, SHAPE_FLAT_X, SHAPE_FLAT_Y} set_shape_t;

    typedef struct {
        int x;
        int y;
        bit last;
    } point_item_t;

    typedef struct {
        logic signed [FRAME_W-1:0] map_x;
        logic signed [FRAME_W-1:0] map_y;
        status_t                   status;
        logic                      last;
    } mapped_point_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic                      s_last_point = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [FRAME_W-1:0] m_map_x;
    logic signed [FRAME_W-1:0] m_map_y;
    logic [1:0]                m_status;
    logic                      m_last_result;

    // Predicted state of the point store and its extremes
    int         held_x [MAX_POINTS];
    int         held_y [MAX_POINTS];
    int         low_x = 0;
    int         high_x = 0;
    int         low_y = 0;
    int         high_y = 0;
    int         held_count = 0;
    bit         dropped = 1'b0;
    frame_cfg_t frame_shadow = '0;

    point_item_t   point_queue[$];
    mapped_point_t pending_results[$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int fail_count = 0;
    bit in_taken = 1'b0;

    bounding_box_point_rescaler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_last_point  (s_last_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_map_x       (m_map_x),
        .m_map_y       (m_map_y),
        .m_status      (m_status),
        .m_last_result (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Linear map of one coordinate into the frame, truncating toward zero
    function automatic logic signed [FRAME_W-1:0] map_coord(int p, int lo, int hi,
                                                             logic signed [FRAME_W-1:0] fmax,
                                                             logic signed [FRAME_W-1:0] fmin);
        longint span;
        longint r;
        span = (longint'(p) - longint'(lo)) * (longint'(fmax) - longint'(fmin));
        r = longint'(fmin) + span / (longint'(hi) - longint'(lo));
        return r[FRAME_W-1:0];
    endfunction

    // Store one accepted point; on the last point queue the mapped set
    task automatic absorb_point(int px, int py, bit last);
        mapped_point_t res;
        if (held_count < MAX_POINTS) begin
            if (held_count == 0) begin
                low_x  = px;
                high_x = px;
                low_y  = py;
                high_y = py;
            end else begin
                if (px < low_x) low_x = px;
                if (px > high_x) high_x = px;
                if (py < low_y) low_y = py;
                if (py > high_y) high_y = py;
            end
            held_x[held_count] = px;
            held_y[held_count] = py;
            held_count++;
        end else begin
            // capacity full: drop the point, extremes untouched
            dropped = 1'b1;
        end
        if (!last) return;
        if (high_x <= low_x || high_y <= low_y) begin
            // flat axis: one error word, x checked first
            res.map_x  = '0;
            res.map_y  = '0;
            res.status = (high_x <= low_x) ? ST_ZERO_X : ST_ZERO_Y;
            res.last   = 1'b1;
            pending_results.push_back(res);
        end else begin
            for (int i = 0; i < held_count; i++) begin
                res.map_x  = map_coord(held_x[i], low_x, high_x,
                                       frame_shadow.fmax_x, frame_shadow.fmin_x);
                res.map_y  = map_coord(held_y[i], low_y, high_y,
                                       frame_shadow.fmax_y, frame_shadow.fmin_y);
                res.status = dropped ? ST_OVERFLOW : ST_OK;
                res.last   = (i == held_count - 1);
                pending_results.push_back(res);
            end
        end
        held_count = 0;
        dropped    = 1'b0;
        low_x      = 0;
        high_x     = 0;
        low_y      = 0;
        high_y     = 0;
    endtask

    task automatic report(string msg);
        if (fail_count < REPORT_CAP) $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Compare the word on the result port against the oldest prediction
    task automatic check_result();
        mapped_point_t want;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result word x=%0d y=%0d status=%0d",
                             m_map_x, m_map_y, m_status));
            return;
        end
        want = pending_results.pop_front();
        if (m_map_x !== want.map_x)
            report($sformatf("map_x %0d, predicted %0d", m_map_x, want.map_x));
        if (m_map_y !== want.map_y)
            report($sformatf("map_y %0d, predicted %0d", m_map_y, want.map_y));
        if (m_status !== want.status)
            report($sformatf("status %0d, predicted %0d", m_status, want.status));
        if (m_last_result !== want.last)
            report($sformatf("last_result %0d, predicted %0d", m_last_result, want.last));
    endtask

    // Sample both handshakes on the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) absorb_point(s_point_x, s_point_y, s_last_point);
        if (aresetn && m_valid && m_ready) check_result();
    end

    // Present the next queued word once the current one is taken; throttle both sides
    always @(negedge aclk) begin
        point_item_t nxt;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (point_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = point_queue.pop_front();
                    s_valid      <= 1'b1;
                    s_point_x    <= nxt.x;
                    s_point_y    <= nxt.y;
                    s_last_point <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic signed [FRAME_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W - FRAME_W){value[FRAME_W-1]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_MAX_X: frame_shadow.fmax_x = value;
            REG_FRAME_MIN_X: frame_shadow.fmin_x = value;
            REG_FRAME_MAX_Y: frame_shadow.fmax_y = value;
            REG_FRAME_MIN_Y: frame_shadow.fmin_y = value;
            default: ;
        endcase
    endtask

    task automatic set_frame(logic signed [FRAME_W-1:0] mx, logic signed [FRAME_W-1:0] nx,
                             logic signed [FRAME_W-1:0] my, logic signed [FRAME_W-1:0] ny);
        apb_write(REG_FRAME_MAX_X, mx);
        apb_write(REG_FRAME_MIN_X, nx);
        apb_write(REG_FRAME_MAX_Y, my);
        apb_write(REG_FRAME_MIN_Y, ny);
    endtask

    // Queue one set of points; the final point carries the last flag
    task automatic push_set(int size, set_shape_t shape);
        int base_x;
        int base_y;
        int x;
        int y;
        base_x = $urandom;
        base_y = $urandom;
        for (int i = 0; i < size; i++) begin
            case (shape)
                SHAPE_FLAT_X: begin
                    x = base_x;
                    y = $urandom;
                end
                SHAPE_FLAT_Y: begin
                    x = $urandom;
                    y = base_y;
                end
                SHAPE_NARROW: begin
                    x = base_x + $urandom_range(8) - 4;
                    y = base_y + $urandom_range(8) - 4;
                end
                default: begin
                    x = $urandom;
                    y = $urandom;
                end
            endcase
            point_queue.push_back('{x, y, i == size - 1});
        end
    endtask

    // Mostly short sets, now and then one around or past capacity
    task automatic fill_random_sets(int budget);
        int         queued;
        int         size;
        int         pick;
        set_shape_t shape;
        queued = 0;
        while (queued < budget) begin
            size  = ($urandom_range(11) == 0) ? $urandom_range(68, 62) : $urandom_range(10, 1);
            pick  = $urandom_range(9);
            shape = (pick == 0) ? SHAPE_FLAT_X :
                    (pick == 1) ? SHAPE_FLAT_Y :
                    (pick < 4)  ? SHAPE_NARROW : SHAPE_WIDE;
            push_set(size, shape);
            queued += size;
        end
    endtask

    // Drain everything, then let the back end settle before touching registers
    task automatic wait_until_idle();
        while (point_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed sets at the widest frame, y mirrored
        sender_idle_pct   = 36;
        receiver_idle_pct = 86;
        set_frame(32767, -32768, -32768, 32767);
        // single point falls into the flat x case
        point_queue.push_back('{0, 0, 1'b1});
        // full coordinate span, including negative truncation
        point_queue.push_back('{COORD_MIN, COORD_MAX, 1'b0});
        point_queue.push_back('{COORD_MAX, COORD_MIN, 1'b0});
        point_queue.push_back('{0, 0, 1'b0});
        point_queue.push_back('{-1, 1, 1'b1});
        // flat x
        point_queue.push_back('{5, 1, 1'b0});
        point_queue.push_back('{5, 9, 1'b1});
        // flat y with x spread
        point_queue.push_back('{1, 7, 1'b0});
        point_queue.push_back('{9, 7, 1'b1});
        // both flat: x error wins
        point_queue.push_back('{3, 3, 1'b0});
        point_queue.push_back('{3, 3, 1'b1});
        // tiny range, heavy rounding
        point_queue.push_back('{0, 10, 1'b0});
        point_queue.push_back('{1, -10, 1'b0});
        point_queue.push_back('{2, 0, 1'b1});
        wait_until_idle();

        // Random frame, one set past capacity first
        set_frame(FRAME_W'($urandom), FRAME_W'($urandom),
                  FRAME_W'($urandom), FRAME_W'($urandom));
        push_set($urandom_range(68, 65), SHAPE_WIDE);
        fill_random_sets(20);
        wait_until_idle();

        // Degenerate frame: every point lands on the frame minimum
        sender_idle_pct   = 86;
        receiver_idle_pct = 36;
        set_frame(32767, 32767, -32768, -32768);
        fill_random_sets(25);
        wait_until_idle();

        // Screen-like frame at full rate
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_frame(639, 0, 0, 479);
        fill_random_sets(25);
        wait_until_idle();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/brp_pkg.sv
hdl/brp_ram.sv
hdl/brp_front.sv
hdl/brp_queue.sv
hdl/brp_back.sv
hdl/bounding_box_point_rescaler.sv
dv/bounding_box_point_rescaler_test.sv
